// ===== design/double_sha512_nonce_search_core_macros.svh =====
// Assertion macros used by the checker file of the nonce search core.
`ifndef DOUBLE_SHA512_NONCE_SEARCH_CORE_MACROS_SVH
`define DOUBLE_SHA512_NONCE_SEARCH_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define DSN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define DSN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dsn_pkg.sv =====
// Package with the SHA-512 constants and a helper function of the nonce search core.
package dsn_pkg;

    localparam int unsigned WordW     = 64;
    localparam int unsigned StepW     = 32;
    localparam int unsigned Rounds    = 80;
    localparam int unsigned RoundW    = 7;
    localparam int unsigned MsgBytes  = 72;
    localparam int unsigned DigBytes  = 64;
    localparam int unsigned AddrW     = 2;
    localparam logic [AddrW-1:0] RegNonceStep = 2'd0;
    localparam logic [StepW-1:0] StepReset    = 32'd1;

    localparam logic [WordW-1:0] PadWord  = 64'h8000000000000000;
    localparam logic [WordW-1:0] LenFirst = WordW'(MsgBytes * 8);
    localparam logic [WordW-1:0] LenSecond = WordW'(DigBytes * 8);

    typedef logic [WordW-1:0] t_word;

    localparam t_word InitH [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

    localparam t_word RoundK [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    // Handshake between the sequencer and the round unit.
    typedef struct packed {
        logic start;
        logic second;
    } t_rnd_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rnd_stat;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

endpackage

// ===== design/dsn_if.sv =====
// Valid/ready channel interfaces for jobs and results.
interface dsn_job_if;
    logic                   valid;
    logic                   ready;
    logic [63:0]            start_nonce;
    logic [63:0]            target;
    logic [63:0]            hash_word_0;
    logic [63:0]            hash_word_1;
    logic [63:0]            hash_word_2;
    logic [63:0]            hash_word_3;
    logic [63:0]            hash_word_4;
    logic [63:0]            hash_word_5;
    logic [63:0]            hash_word_6;
    logic [63:0]            hash_word_7;
    modport source (output valid, start_nonce, target, hash_word_0, hash_word_1,
        hash_word_2, hash_word_3, hash_word_4, hash_word_5, hash_word_6, hash_word_7,
        input ready);
    modport sink (input valid, start_nonce, target, hash_word_0, hash_word_1,
        hash_word_2, hash_word_3, hash_word_4, hash_word_5, hash_word_6, hash_word_7,
        output ready);
endinterface

interface dsn_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] found_nonce;
    logic [63:0] trial_value;
    modport source (output valid, found_nonce, trial_value, input ready);
    modport sink (input valid, found_nonce, trial_value, output ready);
endinterface

// ===== design/double_sha512_nonce_search_core.sv =====
// Top level of the double SHA-512 nonce search core.
// Each trial runs two SHA-512 compressions through one shared round unit at one round per
// cycle. A compression has these steps: the start request, the block load, 80 rounds, the
// digest fold and the done strobe. A trial also steps the nonce before the first pass and
// compares after the second. A job runs trials until the trial value is at most the target
// or the nonce returns to the start. A target of all ones returns at once with a trial
// value of 0. The core takes a job only when idle; the result stays valid until taken.
module double_sha512_nonce_search_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    dsn_job_if.sink                    job,
    dsn_res_if.source                  res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dsn_pkg::AddrW-1:0]  paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    typedef enum logic [2:0] {S_IDLE, S_STEP, S_PASS1, S_WAIT1, S_PASS2, S_WAIT2,
        S_CHECK, S_OUT} t_state;

    t_state                     r_state;
    logic [dsn_pkg::StepW-1:0]  r_step;
    dsn_pkg::t_word             r_nonce;
    dsn_pkg::t_word             r_start;
    dsn_pkg::t_word             r_target;
    dsn_pkg::t_word             r_msg [8];
    dsn_pkg::t_word             r_trial;
    logic                       r_valid;
    dsn_pkg::t_rnd_ctrl         r_ctrl;
    dsn_pkg::t_rnd_stat         w_stat;
    dsn_pkg::t_word             w_dig [8];
    dsn_pkg::t_word             w_blk [16];
    logic                       r_second;

    // Configuration register access.
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr == dsn_pkg::RegNonceStep) prdata = 32'(r_step);
    end

    // Block assembly for the two passes.
    always_comb begin
        for (int i = 0; i < 16; i++) w_blk[i] = '0;
        if (!r_second) begin
            w_blk[0] = r_nonce;
            for (int i = 0; i < 8; i++) w_blk[1+i] = r_msg[i];
            w_blk[9]  = dsn_pkg::PadWord;
            w_blk[15] = dsn_pkg::LenFirst;
        end else begin
            for (int i = 0; i < 8; i++) w_blk[i] = w_dig[i];
            w_blk[8]  = dsn_pkg::PadWord;
            w_blk[15] = dsn_pkg::LenSecond;
        end
    end

    dsn_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (r_ctrl),
        .i_blk    (w_blk),
        .o_stat   (w_stat),
        .o_digest (w_dig)
    );

    assign job.ready       = (r_state == S_IDLE);
    assign res.valid       = r_valid;
    assign res.found_nonce = r_nonce;
    assign res.trial_value = r_trial;

    // Job sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= dsn_pkg::StepReset;
            r_valid  <= 1'b0;
            r_ctrl   <= '0;
            r_second <= 1'b0;
            r_nonce  <= '0;
            r_target <= '0;
        end else begin
            // The round unit is started for one cycle out of each pass state.
            r_ctrl <= '{start: (r_state == S_PASS1) || (r_state == S_PASS2),
                        second: (r_state == S_PASS2)};
            if (psel && penable && pwrite && paddr == dsn_pkg::RegNonceStep) begin
                r_step <= pwdata[dsn_pkg::StepW-1:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (job.valid) begin
                        r_nonce  <= job.start_nonce;
                        r_start  <= job.start_nonce;
                        r_target <= job.target;
                        r_msg[0] <= job.hash_word_0;
                        r_msg[1] <= job.hash_word_1;
                        r_msg[2] <= job.hash_word_2;
                        r_msg[3] <= job.hash_word_3;
                        r_msg[4] <= job.hash_word_4;
                        r_msg[5] <= job.hash_word_5;
                        r_msg[6] <= job.hash_word_6;
                        r_msg[7] <= job.hash_word_7;
                        if (job.target == '1) begin
                            r_trial <= '0;
                            r_valid <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    r_nonce  <= r_nonce + ((r_step == '0) ? dsn_pkg::WordW'(1)
                        : dsn_pkg::WordW'(r_step));
                    r_second <= 1'b0;
                    r_state  <= S_PASS1;
                end
                S_PASS1: begin
                    r_state <= S_WAIT1;
                end
                S_WAIT1: begin
                    if (w_stat.done) begin
                        r_second <= 1'b1;
                        r_state  <= S_PASS2;
                    end
                end
                S_PASS2: begin
                    r_state <= S_WAIT2;
                end
                S_WAIT2: begin
                    if (w_stat.done) begin
                        r_trial <= w_dig[0];
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_trial <= r_target || r_nonce == r_start) begin
                        r_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_OUT: begin
                    if (res.ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/dsn_round.sv =====
// SHA-512 compression unit: one round per cycle with a rolling schedule window.
module dsn_round (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dsn_pkg::t_rnd_ctrl    i_ctrl,
    input  dsn_pkg::t_word        i_blk [16],
    output dsn_pkg::t_rnd_stat    o_stat,
    output dsn_pkg::t_word        o_digest [8]
);
    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FOLD} t_state;

    t_state                       r_state;
    logic [dsn_pkg::RoundW-1:0]   r_round;
    logic                         r_done;
    dsn_pkg::t_word               r_w [16];
    dsn_pkg::t_word               r_v [8];
    dsn_pkg::t_word               r_dig [8];

    dsn_pkg::t_word               w_new;
    dsn_pkg::t_word               w_cur;
    dsn_pkg::t_word               t1;
    dsn_pkg::t_word               t2;
    dsn_pkg::t_word               s0;
    dsn_pkg::t_word               s1;

    // Message schedule: the window shifts by one word each round.
    always_comb begin
        s0 = dsn_pkg::rotr(r_w[1], 1) ^ dsn_pkg::rotr(r_w[1], 8) ^ (r_w[1] >> 7);
        s1 = dsn_pkg::rotr(r_w[14], 19) ^ dsn_pkg::rotr(r_w[14], 61) ^ (r_w[14] >> 6);
        w_new = r_w[0] + s0 + s1 + r_w[9];
        w_cur = r_w[0];
        t1 = r_v[7] + (dsn_pkg::rotr(r_v[4], 14) ^ dsn_pkg::rotr(r_v[4], 18)
            ^ dsn_pkg::rotr(r_v[4], 41)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
            + dsn_pkg::RoundK[r_round] + w_cur;
        t2 = (dsn_pkg::rotr(r_v[0], 28) ^ dsn_pkg::rotr(r_v[0], 34)
            ^ dsn_pkg::rotr(r_v[0], 39))
            + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Round sequencer with working variables and schedule.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_ctrl.start) begin
                        r_w     <= i_blk;
                        r_v     <= dsn_pkg::InitH;
                        r_round <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    if (r_round == dsn_pkg::RoundW'(dsn_pkg::Rounds - 1)) begin
                        r_state <= S_FOLD;
                    end else begin
                        r_round <= r_round + 1'b1;
                    end
                end
                S_FOLD: begin
                    for (int i = 0; i < 8; i++) r_dig[i] <= dsn_pkg::InitH[i] + r_v[i];
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The pass flag is masked off and does not affect the status; both passes use the same rounds.
    assign o_stat.busy = (r_state != S_IDLE) || i_ctrl.second & 1'b0;
    assign o_stat.done = r_done;
    assign o_digest    = r_dig;
endmodule

// ===== design/dsn_checker.sv =====
// Port-level checker for the nonce search core, with its bind statement.
`include "double_sha512_nonce_search_core_macros.svh"
module dsn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        job_valid,
    input logic        job_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [63:0] res_found_nonce
);
    `DSN_ASSERT_IMPL(a_no_job_with_result, i_clk, i_rst_n, res_valid, !job_ready, "ready while result pending")
    `DSN_ASSERT_NEXT(a_busy_after_job, i_clk, i_rst_n, job_valid && job_ready, !job_ready, "ready right after a job")
    `DSN_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, res_valid && !res_ready, res_valid && $stable(res_found_nonce), "result dropped")
    `DSN_ASSERT_NEXT(a_idle_after_res, i_clk, i_rst_n, res_valid && res_ready, job_ready && !res_valid, "not idle after result")
endmodule

bind double_sha512_nonce_search_core dsn_checker u_dsn_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .job_valid       (job.valid),
    .job_ready       (job.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_found_nonce (res.found_nonce)
);
